>>> design/box_average_image_decimator_macros.svh
// Assertion macros for the box average image decimator.
// Each macro samples on aclk and is disabled while aresetn is low.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef BOX_AVERAGE_IMAGE_DECIMATOR_MACROS_SVH
`define BOX_AVERAGE_IMAGE_DECIMATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every clock edge.
`define BAID_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("baid: invariant violated");

// Antecedent at one edge requires the consequent at the next edge.
`define BAID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("baid: sequence check failed");

`else

`define BAID_ASSERT_ALWAYS(lbl, expr)
`define BAID_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/baid_pkg.sv
// Shared types and constants for the box average image decimator.
// Holds field widths, register codes and the reciprocal table for the tile divide.
// No dependencies.
package baid_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 24;   // 256 samples of 16 bits
    localparam int FACTOR_W    = 5;
    localparam int CHAN_CNT_W  = 3;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int TILE_W      = 4;    // position inside a tile, 0..15
    localparam int CMP_W       = 14;   // room for a tile origin plus two tile edges
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 32;

    localparam int unsigned MAX_FACTOR = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_FACTOR  = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_IMAGE_WIDTH   = 2'd2,
        REG_IMAGE_HEIGHT  = 2'd3
    } cfg_reg_t;

    // floor(2^32 / f^2) + 1, exact quotient for any sum below 2^24.
    // Factor 1 bypasses the multiply.
    localparam logic [RECIP_W-1:0] RECIP_TABLE [0:MAX_FACTOR] = '{
        31'd0,
        31'd0,
        31'd1073741825,
        31'd477218589,
        31'd268435457,
        31'd171798692,
        31'd119304648,
        31'd87652394,
        31'd67108865,
        31'd53024288,
        31'd42949673,
        31'd35495598,
        31'd29826162,
        31'd25414008,
        31'd21913099,
        31'd19088744,
        31'd16777217
    };

endpackage

>>> design/box_average_image_decimator.sv
// Box average image decimator: per-column tile sums in one RAM, divide by reciprocal.
// Depends on baid_pkg and box_average_image_decimator_macros.svh.
//
// Usage:
//   s_ channel carries one interleaved sample per transaction in raster order,
//   channel inner. m_ channel carries one tile average per transaction, in tile
//   raster order with the channel inner; m_tlast marks the last average of a frame.
//   Partial tiles at the right and bottom edges are consumed and give no output.
//   cfg_we writes register cfg_index (0 scale factor, 1 channel count, 2 width,
//   3 height) and restarts the frame; write only while the block is idle.
//   The average of a tile passes the stage 1, stage 2 and output registers
//   to m_tvalid. Throughput: one sample per cycle while s_tready is high; the
//   pipe is read sum RAM, add and write back, reciprocal multiply, output register.
//   A sum read in the cycle its previous value is written back is forwarded.
//   When m_tready is low the output register holds its average; samples keep
//   flowing until another finished average needs the output register, then
//   s_tready drops until the pending average is taken.
//   Reset: frame position returns to the origin and the registers take their
//   defaults (factor 2, 3 channels, 640 x 480). The sum RAM needs no clearing:
//   the first sample of each tile overwrites its entry.
`include "box_average_image_decimator_macros.svh"

module box_average_image_decimator
    import baid_pkg::*;
#(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,    // [15:0] sample

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,    // [15:0] average_sample
    output logic                  m_tlast     // frame_done
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = SUM_W + RECIP_W;

    // configuration
    logic [FACTOR_W-1:0]   scale_reg;
    logic [CHAN_CNT_W-1:0] chan_cnt_reg;
    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;

    logic [FACTOR_W-1:0]   f_eff;
    logic [CHAN_CNT_W-1:0] ch_eff;
    logic [CMP_W-1:0]      w_eff;
    logic [CMP_W-1:0]      h_eff;
    logic [CMP_W-1:0]      f_ext;

    // frame position
    logic [CHW-1:0]      chan_reg,        chan_next;
    logic [CW-1:0]       col_idx_reg,     col_idx_next;
    logic [CW-1:0]       col_start_reg,   col_start_next;
    logic [CW-1:0]       tcol_reg,        tcol_next;
    logic [TILE_W-1:0]   col_in_tile_reg, col_in_tile_next;
    logic [HEIGHT_W-1:0] row_idx_reg,     row_idx_next;
    logic [HEIGHT_W-1:0] row_start_reg,   row_start_next;
    logic [TILE_W-1:0]   row_in_tile_reg, row_in_tile_next;

    logic chan_last, col_end, row_end, col_wrap, row_wrap;
    logic col_full, row_full, col_final, row_final;
    logic in_tile, tile_first, tile_last, frame_last;
    logic [FACTOR_W-1:0] f_m1;
    logic [AW-1:0]       rd_addr;

    // handshake
    logic pipe_en, s_accept, out_load;

    // sum RAM
    logic [SUM_W-1:0] sum_mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;
    logic             mem_we;

    // stage 1: read data back, accumulate
    logic                s1_valid_reg;
    logic                s1_first_reg, s1_last_reg, s1_done_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_fwd_hit_reg;
    logic [SUM_W-1:0]    s1_fwd_data_reg;
    logic [SUM_W-1:0]    s1_prior;
    logic [SUM_W-1:0]    acc;

    // stage 2: reciprocal multiply
    logic                s2_valid_reg;
    logic [SUM_W-1:0]    s2_acc_reg;
    logic [RECIP_W-1:0]  s2_recip_reg;
    logic                s2_bypass_reg;
    logic                s2_done_reg;
    logic [PW-1:0]       prod;
    logic [SAMPLE_W-1:0] avg;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg    <= FACTOR_W'(2);
            chan_cnt_reg <= CHAN_CNT_W'(3);
            width_reg    <= WIDTH_W'(640);
            height_reg   <= HEIGHT_W'(480);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCALE_FACTOR:  scale_reg    <= cfg_data[FACTOR_W-1:0];
                REG_CHANNEL_COUNT: chan_cnt_reg <= cfg_data[CHAN_CNT_W-1:0];
                REG_IMAGE_WIDTH:   width_reg    <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg   <= cfg_data[HEIGHT_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (scale_reg == '0)
            f_eff = FACTOR_W'(1);
        else if (scale_reg > FACTOR_W'(MAX_FACTOR))
            f_eff = FACTOR_W'(MAX_FACTOR);
        else
            f_eff = scale_reg;

        if (chan_cnt_reg == '0)
            ch_eff = CHAN_CNT_W'(1);
        else if (chan_cnt_reg > CHAN_CNT_W'(MAX_CHANNELS))
            ch_eff = CHAN_CNT_W'(MAX_CHANNELS);
        else
            ch_eff = chan_cnt_reg;

        if (width_reg == '0)
            w_eff = CMP_W'(1);
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = CMP_W'(width_reg);

        h_eff = (height_reg == '0) ? CMP_W'(1) : CMP_W'(height_reg);
        f_ext = CMP_W'(f_eff);
    end

    // ---------------- position and tile decode ----------------
    always_comb begin
        f_m1 = f_eff - FACTOR_W'(1);

        // a tile counts only if it lies fully inside the image
        col_full  = (CMP_W'(col_start_reg) + f_ext) <= w_eff;
        row_full  = (CMP_W'(row_start_reg) + f_ext) <= h_eff;
        col_final = (CMP_W'(col_start_reg) + (f_ext << 1)) > w_eff;
        row_final = (CMP_W'(row_start_reg) + (f_ext << 1)) > h_eff;
        in_tile   = col_full && row_full;

        tile_first = (col_in_tile_reg == '0) && (row_in_tile_reg == '0);
        tile_last  = (FACTOR_W'(col_in_tile_reg) == f_m1) &&
                     (FACTOR_W'(row_in_tile_reg) == f_m1);

        chan_last  = (CHAN_CNT_W'(chan_reg) + CHAN_CNT_W'(1)) >= ch_eff;
        col_end    = (CMP_W'(col_idx_reg) + CMP_W'(1)) >= w_eff;
        row_end    = (CMP_W'(row_idx_reg) + CMP_W'(1)) >= h_eff;
        col_wrap   = (FACTOR_W'(col_in_tile_reg) + FACTOR_W'(1)) >= f_eff;
        row_wrap   = (FACTOR_W'(row_in_tile_reg) + FACTOR_W'(1)) >= f_eff;
        frame_last = tile_last && col_final && row_final && chan_last;

        rd_addr = AW'(tcol_reg) * AW'(MAX_CHANNELS) + AW'(chan_reg);
    end

    always_comb begin
        chan_next        = chan_reg;
        col_idx_next     = col_idx_reg;
        col_start_next   = col_start_reg;
        tcol_next        = tcol_reg;
        col_in_tile_next = col_in_tile_reg;
        row_idx_next     = row_idx_reg;
        row_start_next   = row_start_reg;
        row_in_tile_next = row_in_tile_reg;

        if (cfg_we) begin
            chan_next        = '0;
            col_idx_next     = '0;
            col_start_next   = '0;
            tcol_next        = '0;
            col_in_tile_next = '0;
            row_idx_next     = '0;
            row_start_next   = '0;
            row_in_tile_next = '0;
        end else if (s_accept) begin
            chan_next = chan_reg + CHW'(1);
            if (chan_last) begin
                chan_next        = '0;
                col_idx_next     = col_idx_reg + CW'(1);
                col_in_tile_next = col_in_tile_reg + TILE_W'(1);
                if (col_wrap) begin
                    col_in_tile_next = '0;
                    col_start_next   = col_idx_reg + CW'(1);
                    tcol_next        = tcol_reg + CW'(1);
                end
                if (col_end) begin
                    col_idx_next     = '0;
                    col_in_tile_next = '0;
                    col_start_next   = '0;
                    tcol_next        = '0;
                    row_idx_next     = row_idx_reg + HEIGHT_W'(1);
                    row_in_tile_next = row_in_tile_reg + TILE_W'(1);
                    if (row_wrap) begin
                        row_in_tile_next = '0;
                        row_start_next   = row_idx_reg + HEIGHT_W'(1);
                    end
                    if (row_end) begin
                        row_idx_next     = '0;
                        row_in_tile_next = '0;
                        row_start_next   = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg        <= '0;
            col_idx_reg     <= '0;
            col_start_reg   <= '0;
            tcol_reg        <= '0;
            col_in_tile_reg <= '0;
            row_idx_reg     <= '0;
            row_start_reg   <= '0;
            row_in_tile_reg <= '0;
        end else begin
            chan_reg        <= chan_next;
            col_idx_reg     <= col_idx_next;
            col_start_reg   <= col_start_next;
            tcol_reg        <= tcol_next;
            col_in_tile_reg <= col_in_tile_next;
            row_idx_reg     <= row_idx_next;
            row_start_reg   <= row_start_next;
            row_in_tile_reg <= row_in_tile_next;
        end
    end

    // ---------------- handshake ----------------
    // pipe moves unless a finished average waits on a full, stalled output
    assign pipe_en  = !s2_valid_reg || !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en;
    assign s_accept = s_tvalid && pipe_en;
    assign out_load = pipe_en && s2_valid_reg;

    // ---------------- sum RAM ----------------
    assign mem_we = pipe_en && s1_valid_reg && !s1_last_reg;

    always_ff @(posedge aclk) begin
        if (mem_we)
            sum_mem[s1_addr_reg] <= acc;
        if (s_accept)
            rd_data_reg <= sum_mem[rd_addr];
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn)
            s1_valid_reg <= 1'b0;
        else if (pipe_en)
            s1_valid_reg <= s_accept && in_tile;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_first_reg    <= tile_first;
            s1_last_reg     <= tile_last;
            s1_done_reg     <= frame_last;
            s1_addr_reg     <= rd_addr;
            s1_sample_reg   <= s_tdata;
            // write-back landing on the same edge as this read
            s1_fwd_hit_reg  <= mem_we && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= acc;
        end
    end

    always_comb begin
        s1_prior = s1_fwd_hit_reg ? s1_fwd_data_reg : rd_data_reg;
        acc      = (s1_first_reg ? '0 : s1_prior) + SUM_W'(s1_sample_reg);
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn)
            s2_valid_reg <= 1'b0;
        else if (pipe_en)
            s2_valid_reg <= s1_valid_reg && s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_acc_reg    <= acc;
            s2_recip_reg  <= RECIP_TABLE[f_eff];
            s2_bypass_reg <= (f_eff == FACTOR_W'(1));
            s2_done_reg   <= s1_done_reg;
        end
    end

    assign prod = PW'(s2_acc_reg) * PW'(s2_recip_reg);
    assign avg  = s2_bypass_reg ? s2_acc_reg[SAMPLE_W-1:0] : prod[RECIP_SHIFT +: SAMPLE_W];

    // ---------------- output register ----------------
    always_comb begin
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= avg;
            m_tlast_reg <= s2_done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- checks ----------------
    `BAID_ASSERT_ALWAYS(a_chan_range, CHAN_CNT_W'(chan_reg) < ch_eff)
    `BAID_ASSERT_ALWAYS(a_col_tile_pos, FACTOR_W'(col_in_tile_reg) < f_eff)
    `BAID_ASSERT_ALWAYS(a_row_tile_pos, FACTOR_W'(row_in_tile_reg) < f_eff)
    `BAID_ASSERT_ALWAYS(a_col_origin, (col_start_reg + CW'(col_in_tile_reg)) == col_idx_reg)
    `BAID_ASSERT_NEXT(a_result_held, s2_valid_reg && !pipe_en, s2_valid_reg)

endmodule

>>> tb/tb.sv
// Testbench for box_average_image_decimator: streams samples, predicts tile averages.
// Directed tile, frame and register cases, then random frames under varied back-pressure.
// Depends on baid_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb
    import baid_pkg::*;
();

    localparam int SUM_DEPTH   = 2048 * 4;
    localparam int LATENCY     = 2;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                frame_done;
    } tile_average_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  m_tlast;

    box_average_image_decimator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // shadow registers, kept at their written widths
    logic [FACTOR_W-1:0]   factor_reg;
    logic [CHAN_CNT_W-1:0] chan_reg;
    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;

    int unsigned col_pos, chan_pos, row_pos, row_in_tile, col_in_tile;
    logic [SUM_W-1:0] column_sums [SUM_DEPTH];
    tile_average_t expected_averages [$];

    int error_count = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned eff_factor();
        if (factor_reg == 0) return 1;
        if (factor_reg > MAX_FACTOR) return MAX_FACTOR;
        return int'(factor_reg);
    endfunction

    function automatic int unsigned eff_chans();
        if (chan_reg == 0) return 1;
        if (chan_reg > 4) return 4;
        return int'(chan_reg);
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > 2048) return 2048;
        return int'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        return int'(height_reg);
    endfunction

    task automatic restart_frame();
        col_pos     = 0;
        chan_pos    = 0;
        row_pos     = 0;
        row_in_tile = 0;
        col_in_tile = 0;
    endtask

    // Tile average predictor: one call per accepted sample.
    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned f, ch, w, h, out_w, out_h, tcol, trow, idx;
        logic [SUM_W-1:0] acc;
        tile_average_t avg;
        f     = eff_factor();
        ch    = eff_chans();
        w     = eff_width();
        h     = eff_height();
        out_w = w / f;
        out_h = h / f;
        if (col_pos < out_w * f && row_pos < out_h * f) begin
            tcol = col_pos / f;
            trow = row_pos / f;
            idx  = tcol * ch + chan_pos;
            acc  = ((row_in_tile == 0 && col_in_tile == 0) ? '0 : column_sums[idx]) +
                   SUM_W'(s);
            if (row_in_tile == f - 1 && col_in_tile == f - 1) begin
                avg.average    = SAMPLE_W'(acc / (f * f));
                avg.frame_done = (tcol == out_w - 1 && trow == out_h - 1 && chan_pos == ch - 1);
                expected_averages.push_back(avg);
            end else begin
                column_sums[idx] = acc;
            end
        end
        chan_pos++;
        if (chan_pos >= ch) begin
            chan_pos = 0;
            col_pos++;
            col_in_tile++;
            if (col_in_tile >= f) col_in_tile = 0;
            if (col_pos >= w) begin
                col_pos     = 0;
                col_in_tile = 0;
                row_pos++;
                row_in_tile++;
                if (row_in_tile >= f) row_in_tile = 0;
                if (row_pos >= h) begin
                    row_pos     = 0;
                    row_in_tile = 0;
                end
            end
        end
    endtask

    // Called at a falling edge with the input stream idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SCALE_FACTOR:  factor_reg = val[FACTOR_W-1:0];
            REG_CHANNEL_COUNT: chan_reg   = val[CHAN_CNT_W-1:0];
            REG_IMAGE_WIDTH:   width_reg  = val[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:  height_reg = val[HEIGHT_W-1:0];
        endcase
        restart_frame();
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input int unsigned f, input int unsigned ch,
                             input int unsigned w, input int unsigned h);
        write_reg(REG_SCALE_FACTOR, CFG_DATA_W'(f));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(ch));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Leaves s_tvalid high on return; the next call or wait_for_averages lowers it.
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accumulate_sample(v);
        @(negedge aclk);
    endtask

    // Holds the stream off until every predicted average has been taken.
    task automatic wait_for_averages(input int extra_cycles);
        s_tvalid <= 1'b0;
        while (expected_averages.size() != 0) @(negedge aclk);
        repeat (extra_cycles) @(negedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0, 1:    return '1;
            2:       return '0;
            default: return SAMPLE_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Reset defaults (factor 2, 3 channels) with a two pixel wide image.
    task automatic test_default_setup();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
        for (int i = 0; i < 12; i++) begin
            case (i % 3)
                0:       send_sample('1);
                1:       send_sample('0);
                default: send_sample(SAMPLE_W'(i / 3 + 1));
            endcase
        end
        wait_for_averages(LATENCY * 3);
    endtask

    // Factor 1 passes samples through; the fourth sample opens a new frame.
    task automatic test_frame_wrap();
        configure(1, 1, 3, 1);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h1234);
        wait_for_averages(LATENCY * 3);
    endtask

    task automatic test_small_image();
        configure(3, 2, 2, 2);
        for (int i = 0; i < 8; i++) send_sample(random_sample());
        wait_for_averages(LATENCY * 3);
    endtask

    // 3x3 image, factor 2: right column and bottom row are dropped.
    task automatic test_edge_remainder();
        configure(2, 1, 3, 3);
        for (int i = 0; i < 9; i++) send_sample(random_sample());
        wait_for_averages(LATENCY * 3);
    endtask

    task automatic test_register_clamps();
        // all zero: every sample is a one pixel frame
        configure(0, 0, 0, 0);
        for (int i = 0; i < 3; i++) send_sample(random_sample());
        wait_for_averages(LATENCY * 3);
        // all ones: upper bits of the data word must be dropped, then factor, channels and width clamped
        configure('1, '1, '1, '1);
        for (int i = 0; i < 8; i++) send_sample(random_sample());
        wait_for_averages(LATENCY * 3);
    endtask

    task automatic test_random_stream(input int items, input int send_pct, input int recv_pct);
        int unsigned f, fe, ch, ce, w, h, frame_len, n, sel, sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < items) begin
            sel = $urandom_range(99);
            if (sel < 60)      f = $urandom_range(1, 4);
            else if (sel < 85) f = $urandom_range(5, 8);
            else if (sel < 95) f = $urandom_range(9, 16);
            else               f = $urandom_range(1) ? 0 : $urandom_range(17, 31);
            fe = (f == 0) ? 1 : (f > MAX_FACTOR ? MAX_FACTOR : f);
            if (fe > 8) begin
                ch = $urandom_range(0, 2);
            end else if ($urandom_range(9) == 0) begin
                ch = $urandom_range(4, 8);
                if (ch == 8) ch = 0;
            end else begin
                ch = $urandom_range(1, 4);
            end
            ce = (ch == 0) ? 1 : (ch > 4 ? 4 : ch);
            w = fe * $urandom_range(1, fe <= 2 ? 6 : (fe <= 4 ? 3 : 1));
            if ($urandom_range(1)) w += $urandom_range(0, fe - 1);
            h = fe * $urandom_range(1, fe <= 2 ? 4 : (fe <= 4 ? 2 : 1));
            if (fe <= 8 && $urandom_range(1)) h += $urandom_range(0, fe - 1);
            configure(f, ch, w, h);
            frame_len = w * h * ce;
            sel = $urandom_range(99);
            if (sel < 60)      n = frame_len * $urandom_range(1, 2);
            else if (sel < 85) n = frame_len + $urandom_range(1, frame_len);
            else               n = $urandom_range(1, frame_len);
            for (int i = 0; i < n; i++) send_sample(random_sample());
            sent += n;
            wait_for_averages(LATENCY * 3);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin : check_average
        tile_average_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_averages.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual %04h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = expected_averages.pop_front();
                if (m_tdata !== want.average) begin
                    error_count++;
                    $display("%0t: average mismatch, expected %04h, actual %04h",
                             $time, want.average, m_tdata);
                end
                if (m_tlast !== want.frame_done) begin
                    error_count++;
                    $display("%0t: frame_done mismatch, expected %b, actual %b",
                             $time, want.frame_done, m_tlast);
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SCALE_FACTOR;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 16;
        recv_idle_pct = 88;
        factor_reg    = 2;
        chan_reg      = 3;
        width_reg     = 640;
        height_reg    = 480;
        restart_frame();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_setup();
        test_frame_wrap();
        test_small_image();
        test_edge_remainder();
        test_register_clamps();
        test_random_stream(500, 16, 88);
        test_random_stream(500, 88, 16);
        test_random_stream(500, 0, 0);

        wait_for_averages(LATENCY * 4);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/baid_pkg.sv
design/box_average_image_decimator.sv
tb/tb.sv
